FILE: rtl/rmbp_pkg.sv
package rmbp_pkg;

  // Default magnitude width of counts and lengths
  localparam int LEN_BITS_DEF = 32;

  // Framing bytes
  localparam logic [7:0] BYTE_STAR = 8'h2A;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_PLUS = 8'h2B;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_VT   = 8'h0B;
  localparam logic [7:0] BYTE_FF   = 8'h0C;
  localparam logic [7:0] BYTE_D0   = 8'h30;
  localparam logic [7:0] BYTE_D9   = 8'h39;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_EMPTY_ARG = 2'd1;
  localparam logic [1:0] KIND_EMPTY_REQ = 2'd2;

  // Trailer skip counts
  localparam logic [1:0] SKIP_NONE  = 2'd0;
  localparam logic [1:0] SKIP_FIRST = 2'd1;
  localparam logic [1:0] SKIP_TRAIL = 2'd2;

  // Parser phases
  typedef enum logic [7:0] {
    PH_IDLE       = 8'b0000_0001,
    PH_COUNT      = 8'b0000_0010,
    PH_LEN        = 8'b0000_0100,
    PH_MARKER     = 8'b0000_1000,
    PH_PAYLOAD    = 8'b0001_0000,
    PH_SKIP_COUNT = 8'b0010_0000,
    PH_SKIP_LEN   = 8'b0100_0000,
    PH_TRAILER    = 8'b1000_0000
  } phase_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       arg_last;
    logic       request_last;
  } result_t;

endpackage

FILE: rtl/rmbp_core.sv
module rmbp_core
  import rmbp_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  output logic       res_valid,
  output result_t    res
);

  phase_t              phase_r, phase_nxt;
  logic [LEN_BITS-1:0] acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic                stop_r, stop_nxt;
  logic [1:0]          skip_r, skip_nxt;
  logic [LEN_BITS-1:0] args_r, args_nxt;
  logic [LEN_BITS-1:0] pay_r, pay_nxt;

  logic                is_cr;
  logic                is_digit;
  logic                is_ws;
  logic                is_sign;
  logic                first;
  logic                num_pos;
  logic                args_le1;
  logic                pay_le1;
  logic [LEN_BITS+3:0] acc_x;
  logic [LEN_BITS+3:0] acc_prod;
  logic [LEN_BITS-1:0] acc_dig;

  // Classify the byte
  assign is_cr    = (byte_in == BYTE_CR);
  assign is_digit = (byte_in >= BYTE_D0) && (byte_in <= BYTE_D9);
  assign is_ws    = (byte_in == BYTE_SPACE) || (byte_in == BYTE_TAB) ||
                    (byte_in == BYTE_LF) || (byte_in == BYTE_VT) || (byte_in == BYTE_FF);
  assign is_sign  = (byte_in == BYTE_PLUS) || (byte_in == BYTE_MINUS);
  assign first    = (skip_r == SKIP_FIRST);
  assign num_pos  = !neg_r && (acc_r != '0);
  assign args_le1 = (args_r[LEN_BITS-1:1] == '0);
  assign pay_le1  = (pay_r[LEN_BITS-1:1] == '0);

  // Saturating acc * 10 + digit
  assign acc_x    = {4'b0000, acc_r};
  assign acc_prod = (acc_x << 3) + (acc_x << 1) + {{LEN_BITS{1'b0}}, byte_in[3:0]};
  assign acc_dig  = (acc_prod[LEN_BITS+3:LEN_BITS] != 4'b0000) ? '1
                                                               : acc_prod[LEN_BITS-1:0];

  // Next state and result
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    stop_nxt  = stop_r;
    skip_nxt  = skip_r;
    args_nxt  = args_r;
    pay_nxt   = pay_r;
    res_valid = 1'b0;
    res       = '{kind: KIND_PAYLOAD, data_byte: 8'h00, arg_last: 1'b0, request_last: 1'b0};

    unique case (phase_r)
      PH_IDLE: begin
        if (byte_in == BYTE_STAR) begin
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          stop_nxt  = 1'b0;
          skip_nxt  = SKIP_FIRST;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (is_cr) begin
          skip_nxt = SKIP_NONE;
          if (phase_r == PH_COUNT) begin
            phase_nxt = PH_SKIP_COUNT;
            if (num_pos) begin
              args_nxt = acc_r;
            end else begin
              args_nxt             = '0;
              res_valid            = 1'b1;
              res.kind             = KIND_EMPTY_REQ;
              res.request_last     = 1'b1;
            end
          end else begin
            phase_nxt = PH_SKIP_LEN;
            if (num_pos) begin
              pay_nxt = acc_r;
            end else begin
              pay_nxt          = '0;
              res_valid        = 1'b1;
              res.kind         = KIND_EMPTY_ARG;
              res.arg_last     = 1'b1;
              res.request_last = args_le1;
              if (args_r != '0) args_nxt = args_r - 1'b1;
            end
          end
        end else if (!stop_r) begin
          priority if (is_digit) begin
            acc_nxt  = acc_dig;
            skip_nxt = SKIP_NONE;
          end else if (first && is_ws) begin
            skip_nxt = skip_r;
          end else if (first && is_sign) begin
            neg_nxt  = (byte_in == BYTE_MINUS);
            skip_nxt = SKIP_NONE;
          end else begin
            skip_nxt = SKIP_NONE;
            stop_nxt = 1'b1;
          end
        end
      end
      PH_SKIP_COUNT: begin
        phase_nxt = (args_r != '0) ? PH_MARKER : PH_IDLE;
      end
      PH_MARKER: begin
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        stop_nxt  = 1'b0;
        skip_nxt  = SKIP_FIRST;
        phase_nxt = PH_LEN;
      end
      PH_SKIP_LEN: begin
        if (pay_r != '0) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          skip_nxt  = SKIP_TRAIL;
          phase_nxt = PH_TRAILER;
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.data_byte    = byte_in;
        res.arg_last     = pay_le1;
        res.request_last = pay_le1 && args_le1;
        if (pay_r != '0) pay_nxt = pay_r - 1'b1;
        if (pay_le1) begin
          pay_nxt   = '0;
          if (args_r != '0) args_nxt = args_r - 1'b1;
          skip_nxt  = SKIP_TRAIL;
          phase_nxt = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (skip_r != SKIP_NONE) skip_nxt = skip_r - 1'b1;
        if (skip_r <= SKIP_FIRST) begin
          phase_nxt = (args_r != '0) ? PH_MARKER : PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Advance the parser on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      stop_r  <= 1'b0;
      skip_r  <= SKIP_NONE;
      args_r  <= '0;
      pay_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      stop_r  <= stop_nxt;
      skip_r  <= skip_nxt;
      args_r  <= args_nxt;
      pay_r   <= pay_nxt;
    end
  end

endmodule

FILE: rtl/resp_multibulk_request_parser_top.sv
// Byte-serial parser for multi-bulk requests.
// Input channel: in_valid / in_ready carry one raw request byte per item
// on in_byte_in. Result channel: out_valid / out_ready carry at most one
// result per input byte: out_kind (payload byte, empty argument or empty
// request), out_data_byte, out_arg_last and out_request_last.
// Framing, count, length and trailer bytes give no result, save the CR
// ending a count or length that is not positive, which gives an empty
// request or empty argument; payload bytes are passed out as they arrive.
// Throughput: one byte per cycle while the receiver takes results. Each
// byte goes through an input register, one pass of the parser's
// next-state logic and the result register, which holds its result if any.
// The parser state update loop sets the one-byte-per-cycle figure.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to waiting for the start of a request.
// When the receiver stalls the result register holds; the input register
// still takes one more byte, then in_ready drops until the result moves.
module resp_multibulk_request_parser_top
  import rmbp_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_arg_last,
  output logic       out_request_last
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res;

  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || step;

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_in;
    end
  end

  rmbp_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load or drop the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_data_byte    = out_res_r.data_byte;
  assign out_arg_last     = out_res_r.arg_last;
  assign out_request_last = out_res_r.request_last;

  // An empty request ends the request but no argument
  a_empty_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == KIND_EMPTY_REQ) |->
      out_res_r.request_last && !out_res_r.arg_last)
    else $error("empty request result with wrong marks");

  // An empty argument always ends its argument
  a_empty_arg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == KIND_EMPTY_ARG) |->
      out_res_r.arg_last && (out_res_r.data_byte == 8'h00))
    else $error("empty argument result with wrong marks");

  // Backpressure only while the input register is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

  // A blocked byte stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !step |=> s1_valid_r && $stable(s1_byte_r))
    else $error("blocked item lost from input register");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rmbp_pkg::*;

  localparam int LB = LEN_BITS_DEF;
  localparam logic [LB+4:0] MAG_MAX = {5'b0, {LB{1'b1}}};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte_in;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic       out_arg_last;
  logic       out_request_last;

  // Parser shadow state
  phase_t        prs_phase;
  logic [LB-1:0] num_mag;
  logic          num_neg;
  logic          num_done;
  logic [LB-1:0] args_left;
  logic [LB-1:0] pay_left;
  logic [1:0]    skip_cnt;

  result_t pending_results[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      burst_left = 0;
  logic [9:0] rdy_tick = '0;

  resp_multibulk_request_parser_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_arg_last     (out_arg_last),
    .out_request_last (out_request_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------

  task automatic parser_clear();
    prs_phase = PH_IDLE;
    num_mag   = '0;
    num_neg   = 1'b0;
    num_done  = 1'b0;
    args_left = '0;
    pay_left  = '0;
    skip_cnt  = SKIP_NONE;
  endtask

  task automatic number_start();
    num_mag  = '0;
    num_neg  = 1'b0;
    num_done = 1'b0;
    skip_cnt = SKIP_FIRST;
  endtask

  // Fold one byte into the decimal field; saturate the magnitude
  task automatic number_take(input logic [7:0] b);
    logic          lead;
    logic [LB+4:0] wide;
    lead = (skip_cnt == SKIP_FIRST);
    if (num_done) return;
    if (b >= BYTE_D0 && b <= BYTE_D9) begin
      wide = num_mag * 10 + (b - BYTE_D0);
      num_mag = (wide > MAG_MAX) ? {LB{1'b1}} : wide[LB-1:0];
      skip_cnt = SKIP_NONE;
      return;
    end
    if (lead && (b inside {BYTE_SPACE, BYTE_TAB, BYTE_LF, BYTE_VT, BYTE_FF})) return;
    if (lead && (b == BYTE_PLUS || b == BYTE_MINUS)) begin
      num_neg  = (b == BYTE_MINUS);
      skip_cnt = SKIP_NONE;
      return;
    end
    skip_cnt = SKIP_NONE;
    num_done = 1'b1;
  endtask

  // Advance the parser by one byte; report the result it gives, if any
  task automatic parse_byte(input logic [7:0] b, output logic hit, output result_t r);
    logic fin;
    hit = 1'b0;
    r   = '0;
    case (prs_phase)
      PH_IDLE: begin
        if (b == BYTE_STAR) begin
          number_start();
          prs_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (b == BYTE_CR) begin
          skip_cnt = SKIP_NONE;
          if (!num_neg && num_mag != 0) begin
            args_left = num_mag;
          end else begin
            args_left      = '0;
            r.kind         = KIND_EMPTY_REQ;
            r.request_last = 1'b1;
            hit            = 1'b1;
          end
          prs_phase = PH_SKIP_COUNT;
        end else begin
          number_take(b);
        end
      end
      PH_SKIP_COUNT: prs_phase = (args_left != 0) ? PH_MARKER : PH_IDLE;
      PH_MARKER: begin
        number_start();
        prs_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b == BYTE_CR) begin
          skip_cnt = SKIP_NONE;
          if (!num_neg && num_mag != 0) begin
            pay_left = num_mag;
          end else begin
            pay_left       = '0;
            r.kind         = KIND_EMPTY_ARG;
            r.arg_last     = 1'b1;
            r.request_last = (args_left <= 1);
            if (args_left != 0) args_left = args_left - 1'b1;
            hit = 1'b1;
          end
          prs_phase = PH_SKIP_LEN;
        end else begin
          number_take(b);
        end
      end
      PH_SKIP_LEN: begin
        if (pay_left != 0) begin
          prs_phase = PH_PAYLOAD;
        end else begin
          skip_cnt  = SKIP_TRAIL;
          prs_phase = PH_TRAILER;
        end
      end
      PH_PAYLOAD: begin
        fin            = (pay_left <= 1);
        r.kind         = KIND_PAYLOAD;
        r.data_byte    = b;
        r.arg_last     = fin;
        r.request_last = fin && (args_left <= 1);
        hit            = 1'b1;
        if (pay_left != 0) pay_left = pay_left - 1'b1;
        if (fin) begin
          pay_left = '0;
          if (args_left != 0) args_left = args_left - 1'b1;
          skip_cnt  = SKIP_TRAIL;
          prs_phase = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (skip_cnt != SKIP_NONE) skip_cnt = skip_cnt - 2'd1;
        if (skip_cnt == SKIP_NONE) prs_phase = (args_left != 0) ? PH_MARKER : PH_IDLE;
      end
      default: prs_phase = PH_IDLE;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result with the oldest expectation, then predict from the accepted byte
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    logic    hit;
    if (!rst_n) begin
      parser_clear();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_kind, out_data_byte, out_arg_last, out_request_last};
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d data %0h arg_last %0b request_last %0b",
                 got.kind, got.data_byte, got.arg_last, got.request_last);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(got.kind));
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("arg_last", 8'(want.arg_last), 8'(got.arg_last));
          check_field("request_last", 8'(want.request_last), 8'(got.request_last));
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_byte_in, hit, want);
        if (hit) pending_results.push_back(want);
      end
    end
  end

  // Receiver: ready always, lightly random, heavily random, then long stalls
  always @(posedge clk) begin
    rdy_tick <= rdy_tick + 10'd1;
    case (rdy_tick[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= (rdy_tick[3:0] >= 4'd6);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Byte senders
  // ---------------------------------------------------------------------------

  // Send one byte; open a new burst after a random gap when the current one ends
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Text followed by CR and LF
  task automatic send_line(input string s);
    send_text(s);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 4))
      0:       return BYTE_SPACE;
      1:       return BYTE_TAB;
      2:       return BYTE_LF;
      3:       return BYTE_VT;
      default: return BYTE_FF;
    endcase
  endfunction

  function automatic logic [7:0] pick_not_cr();
    logic [7:0] j;
    do j = 8'($urandom_range(0, 255)); while (j == BYTE_CR);
    return j;
  endfunction

  // Decimal field with random padding, sign and junk tail, then CR and the skipped byte
  task automatic send_number(input int unsigned mag, input logic minus);
    string      digits;
    logic [7:0] j;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) send_byte(pick_space());
    if (minus) send_byte(BYTE_MINUS);
    else if ($urandom_range(0, 7) == 0) send_byte(BYTE_PLUS);
    if (mag != 0 || $urandom_range(0, 1) != 0) begin
      digits = $sformatf("%0d", mag);
      if ($urandom_range(0, 7) == 0) digits = {"0", digits};
      send_text(digits);
      if ($urandom_range(0, 5) == 0) begin
        do j = pick_not_cr(); while (j >= BYTE_D0 && j <= BYTE_D9);
        send_byte(j);
        repeat ($urandom_range(0, 3)) send_byte(pick_not_cr());
      end
    end
    send_byte(BYTE_CR);
    send_byte(($urandom_range(0, 3) != 0) ? BYTE_LF : 8'($urandom_range(0, 255)));
  endtask

  task automatic send_trailer();
    if ($urandom_range(0, 4) != 0) begin
      send_byte(BYTE_CR);
      send_byte(BYTE_LF);
    end else begin
      repeat (2) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Request with random content; marker, number and trailer bytes may be junk
  task automatic send_random_request();
    int unsigned n_args;
    int unsigned len;
    logic        neg;
    logic        lneg;
    n_args = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
    neg    = ($urandom_range(0, 11) == 0);
    send_byte(BYTE_STAR);
    send_number(n_args, neg);
    if (neg || n_args == 0) return;
    for (int i = 0; i < n_args; i++) begin
      if ($urandom_range(0, 4) != 0) send_text("$");
      else send_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = $urandom_range(13, 40);
        default: len = $urandom_range(1, 12);
      endcase
      lneg = ($urandom_range(0, 11) == 0);
      send_number(len, lneg);
      if (!lneg) repeat (len) send_byte(8'($urandom_range(0, 255)));
      send_trailer();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Drop anything but a star while idle
  task automatic test_idle_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(BYTE_CR);
    send_text("GET");
  endtask

  // Zero, negative, missing and saturated negative counts
  task automatic test_empty_requests();
    send_line("*0");
    send_line("*-3");
    send_line("*");
    send_line("*-99999999999");
  endtask

  // Payload byte extremes, including a CR inside the payload
  task automatic test_payload_extremes();
    send_line("*2");
    send_line("$3");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(BYTE_CR);
    send_line("");
    send_line("$1");
    send_byte(8'h80);
    send_line("");
  endtask

  // Empty arguments in the middle and at the end of a request
  task automatic test_empty_arguments();
    send_line("*3");
    send_line("$0");
    send_line("");
    send_line("$-1");
    send_line("");
    send_line("$1");
    send_text("Z");
    send_line("");
    send_line("*1");
    send_line("$-2");
    send_line("");
  endtask

  // Leading whitespace, signs, junk after digits, doubled and detached signs
  task automatic test_number_syntax();
    send_byte(BYTE_STAR);
    send_byte(BYTE_SPACE);
    send_byte(BYTE_TAB);
    send_byte(BYTE_LF);
    send_byte(BYTE_VT);
    send_byte(BYTE_FF);
    send_line("+2 9x");
    send_line("$3z9");
    send_text("xyz");
    send_line("");
    send_line("$+ 4");
    send_line("");
    send_line("*--1");
    send_line("*+");
  endtask

  // Mostly well-formed requests, some idle noise and some raw garbage
  task automatic test_random_traffic();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 520) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            logic [7:0] j;
            do j = 8'($urandom_range(0, 255)); while (j == BYTE_STAR);
            send_byte(j);
          end
        end
        1:       repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        default: send_random_request();
      endcase
    end
  endtask

  // Saturate count and length; the parser never leaves this request, so run it last
  task automatic test_saturation();
    send_line("*4294967296");
    send_line("$3");
    send_text("abc");
    send_line("");
    send_line("$99999999999");
    repeat (12) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte_in = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_noise();
    test_empty_requests();
    test_payload_extremes();
    test_empty_arguments();
    test_number_syntax();
    test_random_traffic();
    test_saturation();

    // Drain outstanding results, then allow the pipeline to settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rmbp_pkg.sv
rtl/rmbp_core.sv
rtl/resp_multibulk_request_parser_top.sv
tb/sv/tb_top.sv
